>>> src/spatial_object_merge_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spatial object merge table unit
// Clocked, reset-qualified concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_OBJECT_MERGE_TABLE_UNIT_ASSERT_SVH
`define SPATIAL_OBJECT_MERGE_TABLE_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define SOMT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SOMT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SOMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/somt_pkg.sv
// ----------------------------------------------------------------------------
// somt_pkg
// Shared types and constants of the spatial object merge table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package somt_pkg;

    // Request codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_OBJECT  = 2'd0,
        MODE_START   = 2'd1,
        MODE_STOP    = 2'd2,
        MODE_TRIGGER = 2'd3
    } t_mode;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ENTRY   = 3'd0,
        KIND_STARTED = 3'd1,
        KIND_STOPPED = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_EMPTY   = 3'd4
    } t_kind;

    // Input transaction payload
    typedef struct packed {
        t_mode              mode;
        logic [7:0]         class_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        confidence;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         entry_class;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
        logic signed [15:0] entry_z;
        logic [15:0]        entry_confidence;
        logic               last;
    } t_out_item;

    // Stored position word
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_pos;

    // Configuration bus
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned DIST_W  = 15;
    localparam int unsigned LIMIT_W = 2 * DIST_W;

    localparam logic [0:0]         REG_MERGE_DISTANCE = 1'b0;
    localparam logic [DIST_W-1:0]  MERGE_DIST_RST     = 15'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_RST          = LIMIT_W'(20 * 20);

    typedef struct packed {
        logic               psel;
        logic               penable;
        logic               pwrite;
        logic [PADDR_W-1:0] paddr;
        logic [PDATA_W-1:0] pwdata;
    } t_apb_req;

    // Distance unit control and result flags
    typedef struct packed {
        logic valid;
        logic flush;
    } t_dist_ctl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic upgrade;
    } t_dist_res;

endpackage

`default_nettype wire

>>> src/somt_stream_if.sv
// ----------------------------------------------------------------------------
// somt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface somt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/somt_apb_regs.sv
// ----------------------------------------------------------------------------
// somt_apb_regs
// Merge distance register and its registered square used as the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module somt_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  somt_pkg::t_apb_req             i_apb,
    output logic [somt_pkg::PDATA_W-1:0]   o_prdata,
    output logic [somt_pkg::LIMIT_W-1:0]   o_limit
);
    import somt_pkg::*;

    logic [DIST_W-1:0]  r_merge_distance;
    logic [LIMIT_W-1:0] r_limit;
    logic [0:0]         w_reg_idx;
    logic               w_wr;

    assign w_reg_idx = i_apb.paddr[PADDR_W-1:2];
    assign w_wr      = i_apb.psel && i_apb.penable && i_apb.pwrite;

    // Register write and threshold square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_distance <= MERGE_DIST_RST;
            r_limit          <= LIMIT_RST;
        end else begin
            if (w_wr && (w_reg_idx == REG_MERGE_DISTANCE)) begin
                r_merge_distance <= i_apb.pwdata[DIST_W-1:0];
            end
            r_limit <= {{DIST_W{1'b0}}, r_merge_distance}
                     * {{DIST_W{1'b0}}, r_merge_distance};
        end
    end

    // Read back
    always_comb begin
        if (w_reg_idx == REG_MERGE_DISTANCE) begin
            o_prdata = {{(PDATA_W - DIST_W){1'b0}}, r_merge_distance};
        end else begin
            o_prdata = '0;
        end
    end

    assign o_limit = r_limit;

endmodule

`default_nettype wire

>>> src/somt_dist_unit.sv
// ----------------------------------------------------------------------------
// somt_dist_unit
// Shared two-stage squared-distance and confidence compare unit, one entry
// per cycle: squares the axis differences, then sums and tests the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module somt_dist_unit #(
    parameter int IDX_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  somt_pkg::t_dist_ctl          i_ctl,
    input  logic [IDX_W-1:0]             i_idx,
    input  somt_pkg::t_pos               i_new_pos,
    input  somt_pkg::t_pos               i_entry_pos,
    input  logic [15:0]                  i_new_conf,
    input  logic [15:0]                  i_entry_conf,
    input  logic [somt_pkg::LIMIT_W-1:0] i_limit,
    output somt_pkg::t_dist_res          o_res,
    output logic [IDX_W-1:0]             o_idx
);
    import somt_pkg::*;

    logic signed [16:0] w_dx, w_dy, w_dz;
    logic signed [33:0] w_px, w_py, w_pz;
    logic [33:0]        w_sum;

    logic               r_s1_valid;
    logic               r_s1_upg;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [31:0]        r_sq_x, r_sq_y, r_sq_z;

    t_dist_res          r_res;
    logic [IDX_W-1:0]   r_res_idx;

    // Stage 1: differences and squares
    assign w_dx = {i_new_pos.x[15], i_new_pos.x} - {i_entry_pos.x[15], i_entry_pos.x};
    assign w_dy = {i_new_pos.y[15], i_new_pos.y} - {i_entry_pos.y[15], i_entry_pos.y};
    assign w_dz = {i_new_pos.z[15], i_new_pos.z} - {i_entry_pos.z[15], i_entry_pos.z};
    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;
    assign w_pz = w_dz * w_dz;

    // Stage 2: sum of squares against threshold
    assign w_sum = {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_res      <= '0;
        end else begin
            r_s1_valid    <= i_ctl.valid && !i_ctl.flush;
            r_res.valid   <= r_s1_valid && !i_ctl.flush;
            r_res.hit     <= w_sum < {{(34 - LIMIT_W){1'b0}}, i_limit};
            r_res.upgrade <= r_s1_upg;
        end
        // payload, no reset
        r_sq_x    <= w_px[31:0];
        r_sq_y    <= w_py[31:0];
        r_sq_z    <= w_pz[31:0];
        r_s1_upg  <= i_new_conf > i_entry_conf;
        r_s1_idx  <= i_idx;
        r_res_idx <= r_s1_idx;
    end

    assign o_res = r_res;
    assign o_idx = r_res_idx;

endmodule

`default_nettype wire

>>> src/spatial_object_merge_table_unit.sv
// ----------------------------------------------------------------------------
// spatial_object_merge_table_unit
// Table of detected objects that merges nearby detections.
//
// i_obj carries requests: object, start, stop or trigger. o_res carries
// results: one started/stopped marker per start/stop, and per trigger every
// stored entry followed by a done marker (last set), or one empty-list marker.
// Objects produce no result. The merge radius is written over the APB port.
//
// Timing: i_obj is taken only when the sequencer is idle. An object scans the
// stored entries through one shared read port and the distance unit, one
// entry per cycle (read, square, compare). A miss on every entry appends the
// object, or drops it when the table is full; the first close entry absorbs
// it. An empty table appends it directly; before a start or after a stop it is
// ignored. A trigger reads and emits each entry in turn, then a done marker.
// Start and stop emit their marker directly.
//
// Reset empties the table and disables merging; the radius returns to 20.
// No clearing pass is needed. When the receiver stalls, a result waits in
// the output register; the unit still takes the next request and holds its
// own next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_object_merge_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    somt_stream_if.sink                    i_obj,
    somt_stream_if.source                  o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [somt_pkg::PADDR_W-1:0]   paddr,
    input  logic [somt_pkg::PDATA_W-1:0]   pwdata,
    output logic [somt_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import somt_pkg::*;

    `include "spatial_object_merge_table_unit_assert.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_MARK
    } t_state;

    // Control registers
    t_state         r_state,    n_state;
    t_in_item       r_item,     n_item;
    logic           r_accepting, n_accepting;
    logic [CW-1:0]  r_count,    n_count;
    logic [CW-1:0]  r_issue,    n_issue;
    logic           r_rd_valid, n_rd_valid;
    t_kind          r_mark,     n_mark;
    t_out_item      r_out,      n_out;
    logic           r_out_valid, n_out_valid;

    // Entry table and its registered read port
    t_pos           r_mem_pos   [TABLE_DEPTH];
    logic [7:0]     r_mem_label [TABLE_DEPTH];
    logic [15:0]    r_mem_score [TABLE_DEPTH];
    t_pos           r_rd_pos;
    logic [7:0]     r_rd_label;
    logic [15:0]    r_rd_score;
    logic [IW-1:0]  r_rd_idx;

    logic           w_we_entry, w_we_label, w_re, w_flush;
    logic [IW-1:0]  w_waddr, w_raddr;
    t_pos           w_new_pos;
    logic           w_accept, w_out_free;

    t_apb_req           w_apb;
    logic [LIMIT_W-1:0] w_limit;
    t_dist_ctl          w_dist_ctl;
    t_dist_res          w_res;
    logic [IW-1:0]      w_res_idx;
    logic [CW-1:0]      w_res_next;

    // Configuration registers
    assign w_apb  = '{psel: psel, penable: penable, pwrite: pwrite,
                      paddr: paddr, pwdata: pwdata};
    assign pready = 1'b1;

    somt_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apb    (w_apb),
        .o_prdata (prdata),
        .o_limit  (w_limit)
    );

    // Shared distance unit fed from the table read port
    assign w_new_pos  = '{z: r_item.pos_z, y: r_item.pos_y, x: r_item.pos_x};
    assign w_dist_ctl = '{valid: r_rd_valid, flush: w_flush};

    somt_dist_unit #(
        .IDX_W (IW)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_dist_ctl),
        .i_idx        (r_rd_idx),
        .i_new_pos    (w_new_pos),
        .i_entry_pos  (r_rd_pos),
        .i_new_conf   (r_item.confidence),
        .i_entry_conf (r_rd_score),
        .i_limit      (w_limit),
        .o_res        (w_res),
        .o_idx        (w_res_idx)
    );

    assign w_res_next = CW'(w_res_idx) + CW'(1);

    // Handshakes
    assign i_obj.ready = (r_state == ST_IDLE);
    assign w_accept    = i_obj.valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_accepting = r_accepting;
        n_count     = r_count;
        n_issue     = r_issue;
        n_rd_valid  = 1'b0;
        n_mark      = r_mark;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_we_entry  = 1'b0;
        w_we_label  = 1'b0;
        w_waddr     = r_count[IW-1:0];
        w_re        = 1'b0;
        w_raddr     = r_issue[IW-1:0];
        w_flush     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_item  = i_obj.data;
                    n_issue = '0;
                    unique case (i_obj.data.mode)
                        MODE_START: begin
                            n_accepting = 1'b1;
                            n_count     = '0;
                            n_mark      = KIND_STARTED;
                            n_state     = ST_MARK;
                        end
                        MODE_STOP: begin
                            n_accepting = 1'b0;
                            n_mark      = KIND_STOPPED;
                            n_state     = ST_MARK;
                        end
                        MODE_TRIGGER: begin
                            if (r_count == '0) begin
                                n_mark  = KIND_EMPTY;
                                n_state = ST_MARK;
                            end else begin
                                n_state = ST_EMIT_RD;
                            end
                        end
                        MODE_OBJECT: begin
                            if (r_accepting) begin
                                n_state = (r_count == '0) ? ST_APPEND : ST_SCAN;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // Issue one entry read a cycle; stop at the first close entry
            ST_SCAN: begin
                if (r_issue < r_count) begin
                    w_re       = 1'b1;
                    n_issue    = r_issue + CW'(1);
                    n_rd_valid = 1'b1;
                end
                if (w_res.valid && (w_res.hit || (w_res_next == r_count))) begin
                    w_flush    = 1'b1;
                    n_rd_valid = 1'b0;
                    if (w_res.hit) begin
                        w_we_label = w_res.upgrade;
                        w_waddr    = w_res_idx;
                        n_state    = ST_IDLE;
                    end else if (r_count < CW'(TABLE_DEPTH)) begin
                        n_state = ST_APPEND;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_APPEND: begin
                w_we_entry = 1'b1;
                n_count    = r_count + CW'(1);
                n_state    = ST_IDLE;
            end

            ST_EMIT_RD: begin
                w_re    = 1'b1;
                n_state = ST_EMIT_WR;
            end

            ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_out.kind             = KIND_ENTRY;
                    n_out.entry_class      = r_rd_label;
                    n_out.entry_x          = r_rd_pos.x;
                    n_out.entry_y          = r_rd_pos.y;
                    n_out.entry_z          = r_rd_pos.z;
                    n_out.entry_confidence = r_rd_score;
                    n_out.last             = 1'b0;
                    n_out_valid            = 1'b1;
                    n_issue                = r_issue + CW'(1);
                    if ((r_issue + CW'(1)) == r_count) begin
                        n_mark  = KIND_DONE;
                        n_state = ST_MARK;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            ST_MARK: begin
                if (w_out_free) begin
                    n_out       = '0;
                    n_out.kind  = r_mark;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_accepting <= 1'b0;
            r_count     <= '0;
            r_issue     <= '0;
            r_rd_valid  <= 1'b0;
            r_mark      <= KIND_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_accepting <= n_accepting;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_rd_valid  <= n_rd_valid;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    // Entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we_entry) begin
            r_mem_pos[w_waddr]   <= w_new_pos;
            r_mem_score[w_waddr] <= r_item.confidence;
        end
        if (w_we_entry || w_we_label) begin
            r_mem_label[w_waddr] <= r_item.class_id;
        end
        if (w_re) begin
            r_rd_pos   <= r_mem_pos[w_raddr];
            r_rd_label <= r_mem_label[w_raddr];
            r_rd_score <= r_mem_score[w_raddr];
            r_rd_idx   <= w_raddr;
        end
    end

    // Checks
    `SOMT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH),
        "entry count above table depth")
    `SOMT_ASSERT_IMPLY(a_append_room, i_clk, i_rst_n, r_state == ST_APPEND,
        r_count < CW'(TABLE_DEPTH), "append into a full table")
    `SOMT_ASSERT_IMPLY(a_res_in_scan, i_clk, i_rst_n, w_res.valid, r_state == ST_SCAN,
        "stale distance result outside a scan")
    `SOMT_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        w_accept && (i_obj.data.mode == MODE_START), (r_count == '0) && r_accepting,
        "start did not clear the table")

endmodule

`default_nettype wire
